// File: rtl/core/hexb64_pkg.sv
package hexb64_pkg;

	localparam int unsigned GroupNibbles = 6;
	localparam int unsigned GroupSyms    = 4;

	localparam logic [7:0] PadChar  = 8'h3D;
	localparam logic [5:0] SixMask  = 6'h3F;

	// one output symbol with its flags
	typedef struct packed {
		logic [7:0] symbol;
		logic       last;
		logic       bad_digit;
	} b64_sym_t;

	// hex digit decode; bad is set for anything outside 0-9, A-F, a-f
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		logic [7:0] d;
		d = 8'h00;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = c - 8'h30;
			return {1'b0, d[3:0]};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			d = c - 8'h37;
			return {1'b0, d[3:0]};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			d = c - 8'h57;
			return {1'b0, d[3:0]};
		end
		return 5'b1_0000;
	endfunction

	// six-bit value to base64 ASCII
	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [5:0] m;
		m = v & SixMask;
		if (m < 6'd26)      return 8'h41 + {2'b00, m};
		else if (m < 6'd52) return 8'h61 + {2'b00, m} - 8'd26;
		else if (m < 6'd62) return 8'h30 + {2'b00, m} - 8'd52;
		else if (m == 6'd62) return 8'h2B;
		return 8'h2F;
	endfunction

endpackage

// File: rtl/core/hexb64_in_if.sv
interface hexb64_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] hex_char;
	logic       end_of_input;

	modport source (output valid, output hex_char, output end_of_input, input ready);
	modport sink   (input valid, input hex_char, input end_of_input, output ready);
endinterface

// File: rtl/core/hexb64_out_if.sv
interface hexb64_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] symbol;
	logic       last;
	logic       bad_digit;

	modport source (output valid, output symbol, output last, output bad_digit, input ready);
	modport sink   (input valid, input symbol, input last, input bad_digit, output ready);
endinterface

// File: rtl/core/hex_to_base64_encoder.sv
// A group-closing digit is registered into the staged group, which moves into the output
//   buffer once that empties. Throughput: one hex digit per cycle while the stage is free
//   or frees; a group drains at one symbol per cycle while ready is high, so six digits
//   per group keep pace with four symbols. Short groups (end mark) are bounded by the
//   output: four symbols per group. Reset: arst_n low clears the group gatherer, the staged
//   group and the output buffer; no clearing pass, the block is ready right after reset.
module hex_to_base64_encoder (
	input  logic         clk,
	input  logic         arst_n,
	hexb64_in_if.sink    hex_in,
	hexb64_out_if.source b64_out
);
	import hexb64_pkg::*;

	// ---------------- group gatherer ----------------
	logic [23:0] bits_q;   // nibbles gathered so far, left aligned
	logic [2:0]  cnt_q;    // nibbles in current group, 0..5
	logic        err_q;    // non-hex seen in current group

	// staged group: four finished symbols waiting for the output buffer
	b64_sym_t    pend_s1 [GroupSyms];
	logic        pend_v_q;

	// output buffer, drained one symbol per handshake
	b64_sym_t    buf_q [GroupSyms];
	logic [2:0]  rem_q;    // symbols left, 0..4
	logic [1:0]  idx_q;    // next symbol to present

	logic        in_fire, out_fire, emit, load;
	logic [4:0]  dec;
	logic [3:0]  nib;
	logic        bad;
	logic [4:0]  shamt;
	logic [23:0] cur_bits;
	logic [2:0]  new_cnt;
	logic        cur_err;
	logic [2:0]  nsym;
	b64_sym_t    grp [GroupSyms];

	assign out_fire = b64_out.valid & b64_out.ready;
	// staged group moves into the buffer when the buffer empties this cycle
	assign load     = pend_v_q & ((rem_q == 3'd0) | ((rem_q == 3'd1) & out_fire));
	// a new item may be taken whenever the stage is free or frees now
	assign hex_in.ready = ~pend_v_q | load;
	assign in_fire  = hex_in.valid & hex_in.ready;

	// digit decode and insert into the group
	assign dec      = hex_nibble(hex_in.hex_char);
	assign nib      = dec[3:0];
	assign bad      = dec[4];
	assign shamt    = 5'd20 - {cnt_q, 2'b00};
	assign cur_bits = bits_q | ({20'd0, nib} << shamt);
	assign new_cnt  = cnt_q + 3'd1;
	assign cur_err  = err_q | bad;
	assign emit     = in_fire & ((new_cnt == 3'(GroupNibbles)) | hex_in.end_of_input);

	// symbols carrying data: one more than the byte count (odd nibble rounds up)
	always_comb begin
		unique case (new_cnt)
			3'd1, 3'd2: nsym = 3'd2;
			3'd3, 3'd4: nsym = 3'd3;
			default:    nsym = 3'd4;
		endcase
	end

	always_comb begin
		for (int k = 0; k < GroupSyms; k++) begin
			if (3'(k) < nsym)
				grp[k].symbol = b64_char(cur_bits[23 - 6*k -: 6]);
			else
				grp[k].symbol = PadChar;
			grp[k].last      = hex_in.end_of_input & (k == GroupSyms - 1);
			grp[k].bad_digit = cur_err;
		end
	end

	// gatherer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= '0;
			cnt_q  <= '0;
			err_q  <= 1'b0;
		end else if (in_fire) begin
			if (emit) begin
				bits_q <= '0;
				cnt_q  <= '0;
				err_q  <= 1'b0;
			end else begin
				bits_q <= cur_bits;
				cnt_q  <= new_cnt;
				err_q  <= cur_err;
			end
		end
	end

	// staged group payload
	always_ff @(posedge clk) begin
		if (emit) begin
			pend_s1 <= grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
		end else if (emit) begin
			pend_v_q <= 1'b1;
		end else if (load) begin
			pend_v_q <= 1'b0;
		end
	end

	// output buffer
	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= pend_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			rem_q <= 3'(GroupSyms);
			idx_q <= '0;
		end else if (out_fire) begin
			rem_q <= rem_q - 3'd1;
			idx_q <= idx_q + 2'd1;
		end
	end

	assign b64_out.valid     = (rem_q != 3'd0);
	assign b64_out.symbol    = buf_q[idx_q].symbol;
	assign b64_out.last      = buf_q[idx_q].last;
	assign b64_out.bad_digit = buf_q[idx_q].bad_digit;

	// ---------------- checks ----------------
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= 3'(GroupSyms))
		else $error("output buffer count out of range");

	a_load_full: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (rem_q == 3'(GroupSyms)) && (idx_q == 2'd0))
		else $error("buffer not full after load");

	a_emit_staged: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> pend_v_q)
		else $error("closed group not staged");

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(b64_out.valid && b64_out.last) |-> (idx_q == 2'd3) && (rem_q == 3'd1))
		else $error("last flag on wrong symbol");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < 3'(GroupNibbles))
		else $error("nibble count overran group");

endmodule

// File: tb/hexb64_stream_checker.sv
module hexb64_stream_checker (
	input  logic  clk,
	input  logic  arst_n,
	hexb64_in_if  in_ch,
	hexb64_out_if out_ch,
	output int    fail_count,
	output int    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import hexb64_pkg::*;

	localparam string B64Alphabet =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	// shadow of the gatherer: nibbles left-aligned, count, sticky error
	logic [23:0] grp_bits;
	logic [2:0]  grp_count;
	logic        grp_bad;
	int          sym_seen;

	b64_sym_t sym_expected[$];

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch on symbol %0d: %s", $time, sym_seen, msg);
		fail_count++;
	endtask

	// decode one digit into the group; close the group on the sixth digit or end mark
	task automatic absorb_digit(input logic [7:0] c, input logic eoi);
		logic [3:0]  nib;
		logic        bad;
		int unsigned nsym;
		logic [5:0]  six;
		b64_sym_t    s;
		bad = 1'b0;
		if (c >= "0" && c <= "9") begin
			nib = 4'(c - "0");
		end else if (c >= "A" && c <= "F") begin
			nib = 4'(c - "A" + 10);
		end else if (c >= "a" && c <= "f") begin
			nib = 4'(c - "a" + 10);
		end else begin
			nib = 4'h0;
			bad = 1'b1;
		end
		grp_bits = grp_bits | ({20'h0, nib} << (20 - 4 * grp_count));
		grp_bad = grp_bad | bad;
		grp_count++;
		if (grp_count == 3'(GroupNibbles) || eoi) begin
			// one symbol per byte plus one; odd count rounds up to a whole byte
			nsym = (grp_count + 1) / 2 + 1;
			if (nsym > GroupSyms)
				nsym = GroupSyms;
			for (int k = 0; k < GroupSyms; k++) begin
				six = 6'(grp_bits >> (18 - 6 * k));
				s.symbol    = (k < nsym) ? B64Alphabet[six] : PadChar;
				s.last      = eoi && (k == GroupSyms - 1);
				s.bad_digit = grp_bad;
				sym_expected.push_back(s);
			end
			grp_bits  = '0;
			grp_count = '0;
			grp_bad   = 1'b0;
		end
	endtask

	task automatic check_symbol(input b64_sym_t got);
		b64_sym_t want;
		if (sym_expected.size() == 0) begin
			report_mismatch($sformatf("symbol %h arrived with nothing expected", got.symbol));
		end else begin
			want = sym_expected.pop_front();
			if (got.symbol !== want.symbol)
				report_mismatch($sformatf("symbol %h, want %h", got.symbol, want.symbol));
			if (got.last !== want.last)
				report_mismatch($sformatf("last %b, want %b", got.last, want.last));
			if (got.bad_digit !== want.bad_digit)
				report_mismatch($sformatf("bad_digit %b, want %b",
					got.bad_digit, want.bad_digit));
		end
		sym_seen++;
	endtask

	initial begin
		fail_count = 0;
		pending    = 0;
		sym_seen   = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_bits  = '0;
			grp_count = '0;
			grp_bad   = 1'b0;
			sym_expected.delete();
		end else begin
			if (out_ch.valid && out_ch.ready)
				check_symbol('{out_ch.symbol, out_ch.last, out_ch.bad_digit});
			if (in_ch.valid && in_ch.ready)
				absorb_digit(in_ch.hex_char, in_ch.end_of_input);
		end
		pending = sym_expected.size();
	end

endmodule

// File: tb/tb_hex_to_base64_encoder.sv
module tb_hex_to_base64_encoder;
	timeunit 1ns;
	timeprecision 1ps;

	// cycles without any handshake on either side before the run is called hung;
	// the long receiver hold-off is well below this
	localparam int StallLimit = 2000;
	localparam int HoldCycles = 80;
	localparam string HexDigits = "0123456789abcdefABCDEF";

	logic clk;
	logic arst_n;

	hexb64_in_if  hex_in();
	hexb64_out_if b64_out();

	int fail_count;
	int pending;

	// percentages of cycles in which the sender idles / the receiver stalls
	int send_idle_pct;
	int recv_stall_pct;
	// set by stimulus, picked up and counted down by the receiver process
	bit hold_request;
	int digits_sent;
	int quiet_cycles;

	hex_to_base64_encoder uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.hex_in  (hex_in),
		.b64_out (b64_out)
	);

	hexb64_stream_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (hex_in),
		.out_ch     (b64_out),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one digit. Idle cycles come first, so valid is either lowered or
	// raised at an edge, never both. Returns at the edge where the item is taken.
	task automatic send_item(input logic [7:0] c, input logic eoi);
		while ($urandom_range(99) < send_idle_pct) begin
			hex_in.valid <= 1'b0;
			@(posedge clk);
		end
		hex_in.valid        <= 1'b1;
		hex_in.hex_char     <= c;
		hex_in.end_of_input <= eoi;
		do @(posedge clk); while (!hex_in.ready);
		digits_sent++;
	endtask

	// whole message from a string, end mark on its final digit
	task automatic send_msg(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], i == s.len() - 1);
	endtask

	// mostly hex digits of both cases; some characters just outside the
	// hex ranges, and some fully random bytes
	function automatic logic [7:0] pick_char();
		int r;
		r = $urandom_range(99);
		if (r < 80)
			return HexDigits[$urandom_range(HexDigits.len() - 1)];
		if (r < 90) begin
			case ($urandom_range(7))
				0: return 8'h2F;
				1: return 8'h3A;
				2: return 8'h40;
				3: return 8'h47;
				4: return 8'h60;
				5: return 8'h67;
				6: return 8'h00;
				default: return 8'hFF;
			endcase
		end
		return 8'($urandom_range(255));
	endfunction

	// lengths mostly short, so groups of every fill level end the message;
	// now and then a long run of whole groups
	task automatic send_random_msg();
		int n;
		n = ($urandom_range(9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 8);
		for (int i = 0; i < n; i++)
			send_item(pick_char(), i == n - 1);
	endtask

	task automatic random_phase(input int idle_pct, input int stall_pct, input int n_digits);
		int start;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		start = digits_sent;
		while (digits_sent - start < n_digits)
			send_random_msg();
	endtask

	// receiver: random stalls, or a long counted hold-off when asked
	initial begin
		int hold_left;
		hold_left = 0;
		b64_out.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HoldCycles;
			end
			if (hold_left > 0) begin
				b64_out.ready <= 1'b0;
				hold_left--;
			end else begin
				b64_out.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// watchdog: any handshake on either side restarts the count
	always @(posedge clk) begin
		if ((hex_in.valid && hex_in.ready) || (b64_out.valid && b64_out.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= StallLimit) begin
			$display("hex_to_base64_encoder test failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		hex_in.valid        <= 1'b0;
		hex_in.hex_char     <= 8'h00;
		hex_in.end_of_input <= 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_request   = 1'b0;
		digits_sent    = 0;
		quiet_cycles   = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every partial-group length, one full group, a group
		// that spills into the next, byte extremes and near-hex characters
		send_msg("F");
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b1);
		send_msg("9B/");
		send_msg("fFc7");
		send_msg("e3:1d");
		send_msg("FFFFFF");
		send_msg("0G12g`@");

		// back-pressure: receiver holds off while digits keep coming, so the
		// block backs up and has to stall its input
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_request   = 1'b1;
		for (int i = 0; i < 40; i++)
			send_item(pick_char(), i == 39);

		random_phase(0, 0, 40);
		random_phase(65, 0, 40);
		random_phase(0, 65, 40);
		random_phase(31, 31, 40);

		hex_in.valid <= 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;

		// checker count is read away from the active edge
		do @(negedge clk); while (pending != 0);
		repeat (10) @(posedge clk);

		if (fail_count == 0)
			$display("hex_to_base64_encoder test passed");
		else
			$display("hex_to_base64_encoder test failed");
		$finish;
	end

endmodule
